[rtl/core/tdr_pkg.sv]
// Shared types and constants for the triangle depth rasterizer.
// No dependencies; imported by every module of the block.
package tdr_pkg;

	localparam int COORD_W = 9;
	localparam int DEPTH_W = 16;
	localparam int ADDR_W  = 16;
	localparam int NUM_W   = 28;
	localparam int STEP_W  = 18;
	localparam int CMD_W   = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic signed [DEPTH_W-1:0] FAR_DEPTH = 16'sd32767;

	typedef struct packed {
		logic [COORD_W-1:0]        x1;
		logic [COORD_W-1:0]        y1;
		logic signed [DEPTH_W-1:0] d1;
		logic [COORD_W-1:0]        x2;
		logic [COORD_W-1:0]        y2;
		logic signed [DEPTH_W-1:0] d2;
	} edge_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [7:0]       rx;
		logic [7:0]       ry;
		edge_t            lg;
		edge_t            sa;
		edge_t            sb;
	} job_t;

endpackage

[rtl/core/tdr_front.sv]
// Front end: accepts requests, maps vertices to screen, builds edges, picks the long edge.
// Depends on tdr_pkg.
module tdr_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [159:0]                s_tdata,
	input  logic [tdr_pkg::CMD_W-1:0]   s_tuser,
	input  logic [tdr_pkg::COORD_W-1:0] frame_width,
	input  logic [tdr_pkg::COORD_W-1:0] frame_height,
	output logic                        job_valid,
	input  logic                        job_ready,
	output tdr_pkg::job_t               job
);
	import tdr_pkg::*;

	function automatic logic [COORD_W-1:0] map_coord(input logic [15:0] q,
			input logic [COORD_W-1:0] size);
		logic [24:0] p;
		p = {~q[15], q[14:0]} * size;
		return p[24:16];
	endfunction

	function automatic edge_t mk_edge(input logic [COORD_W-1:0] xa, input logic [COORD_W-1:0] ya,
			input logic signed [DEPTH_W-1:0] da, input logic [COORD_W-1:0] xb,
			input logic [COORD_W-1:0] yb, input logic signed [DEPTH_W-1:0] db);
		edge_t e;
		if (ya < yb) begin
			e = '{x1: xa, y1: ya, d1: da, x2: xb, y2: yb, d2: db};
		end else begin
			e = '{x1: xb, y1: yb, d1: db, x2: xa, y2: ya, d2: da};
		end
		return e;
	endfunction

	logic                        valid_s1;
	logic [CMD_W-1:0]            cmd_s1;
	logic [7:0]                  rx_s1, ry_s1;
	logic [COORD_W-1:0]          x_s1 [3];
	logic [COORD_W-1:0]          y_s1 [3];
	logic signed [DEPTH_W-1:0]   d_s1 [3];
	edge_t                       e [3];
	logic [COORD_W-1:0]          h [3];
	logic [1:0]                  longest;
	logic [COORD_W-1:0]          best1;

	assign s_tready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			x_s1[0] <= map_coord(s_tdata[15:0], frame_width);
			y_s1[0] <= map_coord(s_tdata[31:16], frame_height);
			d_s1[0] <= s_tdata[47:32];
			x_s1[1] <= map_coord(s_tdata[63:48], frame_width);
			y_s1[1] <= map_coord(s_tdata[79:64], frame_height);
			d_s1[1] <= s_tdata[95:80];
			x_s1[2] <= map_coord(s_tdata[111:96], frame_width);
			y_s1[2] <= map_coord(s_tdata[127:112], frame_height);
			d_s1[2] <= s_tdata[143:128];
			rx_s1   <= s_tdata[151:144];
			ry_s1   <= s_tdata[159:152];
		end
	end

	always_comb begin
		e[0] = mk_edge(x_s1[0], y_s1[0], d_s1[0], x_s1[1], y_s1[1], d_s1[1]);
		e[1] = mk_edge(x_s1[1], y_s1[1], d_s1[1], x_s1[2], y_s1[2], d_s1[2]);
		e[2] = mk_edge(x_s1[2], y_s1[2], d_s1[2], x_s1[0], y_s1[0], d_s1[0]);
		for (int i = 0; i < 3; i++) begin
			h[i] = e[i].y2 - e[i].y1;
		end
		longest = 2'd0;
		best1   = h[0];
		if (h[1] > best1) begin
			longest = 2'd1;
			best1   = h[1];
		end
		if (h[2] > best1) begin
			longest = 2'd2;
		end
		job.cmd = cmd_s1;
		job.rx  = rx_s1;
		job.ry  = ry_s1;
		case (longest)
			2'd1: begin
				job.lg = e[1]; job.sa = e[2]; job.sb = e[0];
			end
			2'd2: begin
				job.lg = e[2]; job.sa = e[0]; job.sb = e[1];
			end
			default: begin
				job.lg = e[0]; job.sa = e[1]; job.sb = e[2];
			end
		endcase
	end

endmodule

[rtl/core/tdr_queue.sv]
// Two-entry job queue between front end and back end.
// Depends on tdr_pkg.
module tdr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tdr_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tdr_pkg::job_t pop_data
);
	import tdr_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop) rd_q <= !rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

endmodule

[rtl/core/tdr_div.sv]
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on tdr_pkg.
module tdr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tdr_pkg::NUM_W-1:0]   num,
	input  logic [tdr_pkg::COORD_W-1:0]        den,
	output logic                               done,
	output logic signed [tdr_pkg::NUM_W-1:0]   quo,
	output logic [tdr_pkg::COORD_W-1:0]        rem,
	output logic                               neg
);
	import tdr_pkg::*;

	localparam int MAG_W = NUM_W - 1;

	logic [MAG_W-1:0]   q_q;
	logic [COORD_W-1:0] r_q;
	logic [COORD_W-1:0] den_q;
	logic [4:0]         cnt_q;
	logic               busy_q, neg_q, done_q;
	logic [COORD_W:0]   r_sh;
	logic [NUM_W-1:0]   mag;

	assign mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign r_sh = {r_q, q_q[MAG_W-1]};
	assign done = done_q;
	assign neg  = neg_q;
	assign rem  = r_q;
	assign quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 5'd0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MAG_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= mag[MAG_W-1:0];
			r_q   <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			if (r_sh >= {1'b0, den_q}) begin
				r_q <= COORD_W'(r_sh - {1'b0, den_q});
				q_q <= {q_q[MAG_W-2:0], 1'b1};
			end else begin
				r_q <= r_sh[COORD_W-1:0];
				q_q <= {q_q[MAG_W-2:0], 1'b0};
			end
		end
	end

endmodule

[rtl/core/tdr_back.sv]
// Back end: depth store, clear sweep, scanline and span walker, read and result register.
// Depends on tdr_pkg and tdr_div.
module tdr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        job_valid,
	output logic                        job_ready,
	input  tdr_pkg::job_t               job,
	input  logic [tdr_pkg::COORD_W-1:0] frame_width,
	input  logic [tdr_pkg::COORD_W-1:0] frame_height,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,
	output logic [0:0]                  m_tuser
);
	import tdr_pkg::*;

	localparam logic [3:0] ST_WIPE  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CLEAR = 4'd2;
	localparam logic [3:0] ST_READ  = 4'd3;
	localparam logic [3:0] ST_RESP  = 4'd4;
	localparam logic [3:0] ST_PASS  = 4'd5;
	localparam logic [3:0] ST_MUL   = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_SPAN  = 4'd8;
	localparam logic [3:0] ST_PIX   = 4'd9;
	localparam logic [3:0] ST_LINE  = 4'd10;

	logic [3:0]                state_q;
	job_t                      job_q;
	logic                      pass_q;
	logic [2:0]                k_q;
	logic [COORD_W-1:0]        y_q, x_q, xl_q, xs_q, xhi_q, w_q, sr_q, racc_q;
	logic signed [DEPTH_W-1:0] dl_q, ds_q, dlo_q;
	logic signed [16:0]        dn_q;
	logic signed [STEP_W-1:0]  sq_q, acc_q;
	logic                      nneg_q;
	logic signed [NUM_W-1:0]   prod_q;
	logic [COORD_W-1:0]        den_q;
	logic                      start_q;
	logic [ADDR_W-1:0]         wipe_q;
	logic                      out_valid_q;
	logic [DEPTH_W-1:0]        out_depth_q;
	logic [DEPTH_W-1:0]        mem [2**ADDR_W];
	logic [DEPTH_W-1:0]        rdata_q;

	edge_t                     lg, sh;
	logic [COORD_W-1:0]        lh, shh, den;
	logic signed [9:0]         tl, ts, b;
	logic signed [16:0]        a;
	logic signed [26:0]        prod;
	logic                      div_done, div_neg;
	logic signed [NUM_W-1:0]   quo;
	logic [COORD_W-1:0]        rem;
	logic                      adj;
	logic [COORD_W:0]          rs;
	logic signed [STEP_W-1:0]  pix_depth;
	logic                      in_frame, mem_we;
	logic [ADDR_W-1:0]         waddr;
	logic [DEPTH_W-1:0]        wdata;
	logic                      out_free;
	logic                      last_pass;

	assign lg        = job_q.lg;
	assign sh        = pass_q ? job_q.sb : job_q.sa;
	assign lh        = lg.y2 - lg.y1;
	assign shh       = sh.y2 - sh.y1;
	assign tl        = $signed({1'b0, y_q}) - $signed({1'b0, lg.y1});
	assign ts        = $signed({1'b0, y_q}) - $signed({1'b0, sh.y1});
	assign job_ready = state_q == ST_IDLE;
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_depth_q;
	assign m_tuser   = 1'b1;
	assign last_pass = pass_q;

	always_comb begin
		case (k_q)
			3'd0: begin
				a = 17'(($signed({1'b0, lg.x2}) - $signed({1'b0, lg.x1})));
				b = tl; den = lh;
			end
			3'd1: begin
				a = 17'(lg.d2) - 17'(lg.d1);
				b = tl; den = lh;
			end
			3'd2: begin
				a = 17'(($signed({1'b0, sh.x2}) - $signed({1'b0, sh.x1})));
				b = ts; den = shh;
			end
			3'd3: begin
				a = 17'(sh.d2) - 17'(sh.d1);
				b = ts; den = shh;
			end
			default: begin
				a = dn_q; b = 10'sd1; den = w_q;
			end
		endcase
		prod = a * b;
	end

	assign adj       = div_neg && (rem != '0);
	assign rs        = {1'b0, racc_q} + {1'b0, sr_q};
	assign pix_depth = STEP_W'(dlo_q) + acc_q + STEP_W'(nneg_q && (racc_q != '0));
	assign in_frame  = (x_q < frame_width) && !x_q[8] && (y_q < frame_height) && !y_q[8];
	assign mem_we    = state_q == ST_WIPE || state_q == ST_CLEAR || (state_q == ST_PIX && in_frame);
	assign waddr     = (state_q == ST_PIX) ? {y_q[7:0], x_q[7:0]} : wipe_q;
	assign wdata     = (state_q == ST_PIX) ? pix_depth[DEPTH_W-1:0] : FAR_DEPTH;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_q <= mem[{job_q.ry, job_q.rx}];
	end

	tdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (prod_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo),
		.rem    (rem),
		.neg    (div_neg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WIPE;
			wipe_q      <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pass_q      <= 1'b0;
			k_q         <= '0;
		end else begin
			start_q <= state_q == ST_MUL;
			if (out_valid_q && m_tready && state_q != ST_RESP) out_valid_q <= 1'b0;
			case (state_q)
				ST_WIPE, ST_CLEAR: begin
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == '1) state_q <= (state_q == ST_WIPE) ? ST_IDLE : ST_RESP;
				end
				ST_IDLE: begin
					if (job_valid) begin
						job_q  <= job;
						pass_q <= 1'b0;
						wipe_q <= '0;
						case (job.cmd)
							CMD_CLEAR: state_q <= ST_CLEAR;
							CMD_DRAW:  state_q <= ST_PASS;
							CMD_READ:  state_q <= ST_READ;
							default:   state_q <= ST_RESP;
						endcase
					end
				end
				ST_READ: state_q <= ST_RESP;
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_depth_q <= (job_q.cmd == CMD_READ) ? rdata_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				ST_PASS: begin
					if (lh == '0 || shh == '0) begin
						if (last_pass) state_q <= ST_RESP;
						else pass_q <= 1'b1;
					end else begin
						y_q     <= sh.y1;
						k_q     <= 3'd0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= NUM_W'(prod);
					den_q   <= den;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						k_q <= k_q + 3'd1;
						case (k_q)
							3'd0: begin
								xl_q <= lg.x1 + quo[COORD_W-1:0]; state_q <= ST_MUL;
							end
							3'd1: begin
								dl_q <= lg.d1 + quo[DEPTH_W-1:0]; state_q <= ST_MUL;
							end
							3'd2: begin
								xs_q <= sh.x1 + quo[COORD_W-1:0]; state_q <= ST_MUL;
							end
							3'd3: begin
								ds_q <= sh.d1 + quo[DEPTH_W-1:0]; state_q <= ST_SPAN;
							end
							default: begin
								sq_q    <= quo[STEP_W-1:0] - STEP_W'(adj);
								sr_q    <= adj ? w_q - rem : rem;
								nneg_q  <= div_neg;
								acc_q   <= '0;
								racc_q  <= '0;
								state_q <= ST_PIX;
							end
						endcase
					end
				end
				ST_SPAN: begin
					if (xl_q == xs_q) begin
						state_q <= ST_LINE;
					end else begin
						if (xl_q < xs_q) begin
							x_q <= xl_q; xhi_q <= xs_q; dlo_q <= dl_q;
							w_q <= xs_q - xl_q; dn_q <= 17'(ds_q) - 17'(dl_q);
						end else begin
							x_q <= xs_q; xhi_q <= xl_q; dlo_q <= ds_q;
							w_q <= xl_q - xs_q; dn_q <= 17'(dl_q) - 17'(ds_q);
						end
						k_q     <= 3'd4;
						state_q <= ST_MUL;
					end
				end
				ST_PIX: begin
					if (x_q == xhi_q) begin
						state_q <= ST_LINE;
					end else begin
						x_q <= x_q + 1'b1;
						if (rs >= {1'b0, w_q}) begin
							racc_q <= COORD_W'(rs - {1'b0, w_q});
							acc_q  <= acc_q + sq_q + STEP_W'(1);
						end else begin
							racc_q <= rs[COORD_W-1:0];
							acc_q  <= acc_q + sq_q;
						end
					end
				end
				ST_LINE: begin
					if (y_q == sh.y2) begin
						if (last_pass) state_q <= ST_RESP;
						else begin
							pass_q  <= 1'b1;
							state_q <= ST_PASS;
						end
					end else begin
						y_q     <= y_q + 1'b1;
						k_q     <= 3'd0;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/triangle_depth_rasterizer.sv]
// Top level: triangle depth rasterizer with a 256x256 depth store.
// Depends on tdr_pkg, tdr_front, tdr_queue, tdr_back (which holds tdr_div).
// A draw uses the divider five times per scanline, then walks the span at one pixel per cycle.
// After reset the store is swept to far depth before the back end takes any job.
// Configuration writes are taken every cycle; frame size resets to 256 by 256.
module triangle_depth_rasterizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [159:0]                s_tdata,  // ax,ay,az,bx,by,bz,cx,cy,cz,read_x,read_y
	input  logic [tdr_pkg::CMD_W-1:0]   s_tuser,  // command
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // read_depth
	output logic [0:0]                  m_tuser,  // done_res
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [0:0]                  cfg_index,
	input  logic [tdr_pkg::COORD_W-1:0] cfg_data
);
	import tdr_pkg::*;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	logic [COORD_W-1:0] width_q, height_q;
	logic               fq_valid, fq_ready, bq_valid, bq_ready;
	job_t               fq_job, bq_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tdr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.frame_width  (width_q),
		.frame_height (height_q),
		.job_valid    (fq_valid),
		.job_ready    (fq_ready),
		.job          (fq_job)
	);

	tdr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_job),
		.pop_valid  (bq_valid),
		.pop_ready  (bq_ready),
		.pop_data   (bq_job)
	);

	tdr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (bq_valid),
		.job_ready    (bq_ready),
		.job          (bq_job),
		.frame_width  (width_q),
		.frame_height (height_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser)
	);

endmodule
